@@ rtl/ddcs_pkg.sv @@
package ddcs_pkg;

	localparam int FRAME_BITS = 16;
	localparam int BIT_W      = 4;
	localparam int POS_W      = 3;
	localparam logic [7:0] NOOP_BYTE = 8'h00;

	localparam logic OP_TARGETED = 1'b0;
	localparam logic OP_BROADCAST = 1'b1;

	// Control from the sequencer to the frame shifter.
	typedef struct packed {
		logic             start;
		logic             next_frame;
		logic             shift;
		logic [POS_W-1:0] pos_next;
	} ctrl_t;

	// Frame for one chain position: address/data, or a no-op of zeros.
	function automatic logic [FRAME_BITS-1:0] frame_word(
		input logic             op,
		input logic [POS_W-1:0] target,
		input logic [POS_W-1:0] pos,
		input logic [7:0]       addr,
		input logic [7:0]       data
	);
		logic hit;
		hit = (op == OP_BROADCAST) || (target == pos);
		frame_word = hit ? {addr, data} : {NOOP_BYTE, NOOP_BYTE};
	endfunction

endpackage

@@ rtl/ddcs_seq.sv @@
module ddcs_seq
	import ddcs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic             out_fire,
	input  logic [POS_W-1:0] count,
	output logic             busy,
	output logic             last,
	output ctrl_t            ctrl
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SEND = 1'b1;

	logic             state_q;
	logic [BIT_W-1:0] bit_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] n_q;
	logic             frame_end;

	assign busy      = (state_q == ST_SEND);
	assign frame_end = (bit_q == BIT_W'(FRAME_BITS - 1));
	assign last      = busy && frame_end && (pos_q == n_q);

	always_comb begin
		ctrl.start      = in_fire && (count != '0);
		ctrl.next_frame = out_fire && frame_end && !last;
		ctrl.shift      = out_fire && !frame_end;
		ctrl.pos_next   = pos_q + POS_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
			pos_q   <= '0;
			n_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctrl.start) begin
						state_q <= ST_SEND;
						bit_q   <= '0;
						pos_q   <= POS_W'(1);
						n_q     <= count;
					end
				end
				ST_SEND: begin
					if (out_fire) begin
						if (last) begin
							state_q <= ST_IDLE;
						end else if (frame_end) begin
							bit_q <= '0;
							pos_q <= ctrl.pos_next;
						end else begin
							bit_q <= bit_q + BIT_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/ddcs_shifter.sv @@
module ddcs_shifter
	import ddcs_pkg::*;
(
	input  logic             clk,
	input  ctrl_t            ctrl,
	input  logic             op,
	input  logic [POS_W-1:0] target_chip,
	input  logic [7:0]       reg_addr,
	input  logic [7:0]       data_byte,
	output logic             serial_bit
);

	logic                  op_q;
	logic [POS_W-1:0]      target_q;
	logic [7:0]            addr_q;
	logic [7:0]            data_q;
	logic [FRAME_BITS-1:0] shift_q;

	assign serial_bit = shift_q[FRAME_BITS-1];

	// The first frame is built from the incoming word, later ones from the held copy.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			op_q     <= op;
			target_q <= target_chip;
			addr_q   <= reg_addr;
			data_q   <= data_byte;
			shift_q  <= frame_word(op, target_chip, POS_W'(1), reg_addr, data_byte);
		end else if (ctrl.next_frame) begin
			shift_q <= frame_word(op_q, target_q, ctrl.pos_next, addr_q, data_q);
		end else if (ctrl.shift) begin
			shift_q <= {shift_q[FRAME_BITS-2:0], 1'b0};
		end
	end

endmodule

@@ rtl/display_driver_chain_serializer.sv @@
// The first bit is presented in the cycle after the input word is accepted.
// One input word is sent as N frames of 16 bits, N the chain length (at most
// MAX_CHIPS); the single frame shift register emits one bit per cycle while the
// output side does not stall, and the input side is held off until the last bit leaves.
// Reset (arst_n low, asynchronous): idle, no output, chain length register set to 3.
module display_driver_chain_serializer
	import ddcs_pkg::*;
#(
	parameter int MAX_CHIPS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: chain length, written whenever cfg_we is high.
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	// Input word stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [2:0] target_chip, [10:3] reg_addr, [18:11] data_byte, rest 0
	input  logic        s_tuser,   // [0] op
	// Serial bit stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] serial_bit, rest 0
	output logic        m_tlast    // last_bit
);

	logic [2:0]       chip_count_q;
	logic [POS_W-1:0] count_eff;
	logic             in_fire;
	logic             out_fire;
	logic             busy;
	logic             last;
	logic             serial_bit;
	ctrl_t            ctrl;

	// The chain length register; values above MAX_CHIPS are clamped on use.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_count_q <= 3'd3;
		end else if (cfg_we) begin
			chip_count_q <= cfg_wdata;
		end
	end

	assign count_eff = (chip_count_q > 3'(MAX_CHIPS)) ? POS_W'(MAX_CHIPS) : chip_count_q;

	// A new word is taken only while no burst is in flight. A zero-length chain
	// consumes the word and sends nothing.
	assign s_tready = !busy;
	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	ddcs_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_fire (out_fire),
		.count    (count_eff),
		.busy     (busy),
		.last     (last),
		.ctrl     (ctrl)
	);

	// Frames go out MSB first: address byte, then data byte, position 1 first.
	ddcs_shifter u_shifter (
		.clk         (clk),
		.ctrl        (ctrl),
		.op          (s_tuser),
		.target_chip (s_tdata[2:0]),
		.reg_addr    (s_tdata[10:3]),
		.data_byte   (s_tdata[18:11]),
		.serial_bit  (serial_bit)
	);

	assign m_tvalid = busy;
	assign m_tdata  = {7'b0, serial_bit};
	assign m_tlast  = last;

	// Input and output sides are never active together.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(s_tready && m_tvalid))
		else $error("input ready while a burst is in flight");

	// The flagged bit ends the burst.
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("output still valid after the last bit");

	// A word accepted with a nonempty chain starts a burst.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (count_eff != '0)) |=> m_tvalid)
		else $error("burst did not start");

	// An empty chain produces no output.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (count_eff == '0)) |=> !m_tvalid)
		else $error("output from an empty chain");

endmodule
